>>> hw/rtl/pfla_pkg.sv
// Shared types and constants of the page free-list allocator.
package pfla_pkg;

    localparam int MAX_PAGES   = 1024;
    localparam int PAGE_W      = $clog2(MAX_PAGES);
    localparam int COUNT_W     = PAGE_W + 1;
    localparam int STATUS_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] LIMIT_MIN   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] LIMIT_MAX   = COUNT_W'(MAX_PAGES);
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(MAX_PAGES);

    // Request kinds.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd4;

    typedef struct packed {
        logic              func;
        logic [PAGE_W-1:0] page_id;
    } pfla_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   result_page;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  pages_in_use_count;
    } pfla_rsp_t;

    // One entry of the link store: free mark above the next-page link.
    typedef struct packed {
        logic              mark;
        logic [PAGE_W-1:0] link;
    } pfla_entry_t;

endpackage

>>> hw/rtl/page_free_list_allocator_top.sv
// Top level of the page free-list allocator.
//
// The block hands out page ids from a pool in which page 0 is the header and
// page 1 exists from reset, so the page count starts at 2. A request item is
// taken on the start/busy command channel: it is accepted at a rising edge
// where start is high and busy is low. An allocate item pops the head of the
// list of freed pages, or grows the page count up to the configured limit. A
// free item checks the id and pushes the page onto the list head.
// Every item produces exactly one result item, shown on rsp for one cycle
// with done high. The receiver cannot stall the block; it must take the
// result in that cycle.
// The accepting edge latches the request and reads the link memory; the
// execute state writes back and fills the result register, and done rises
// at the edge that ends it. busy is high in the execute (write-back) state;
// the result register lets the next item enter at the edge that takes the
// result. The page limit is written on the cfg channel (cfg_valid/cfg_ready);
// the user must write it only while the block is idle, which the block
// itself does not enforce. Reset restores the page count, the list head and
// the limit at once; no clearing pass runs.
module page_free_list_allocator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pfla_pkg::pfla_req_t req,
    output logic                done,
    output pfla_pkg::pfla_rsp_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [pfla_pkg::COUNT_W-1:0] cfg_data
);
    import pfla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0]  limit_reg;
    logic                page1_wr_reg, page1_wr_next;
    logic                done_reg;
    pfla_rsp_t           rsp_reg, rsp_next;

    // Latched request and memory read result.
    logic                func_reg;
    logic [PAGE_W-1:0]   addr_reg;
    pfla_entry_t         rd_data_reg;

    // Link memory: free mark and next-page link per page.
    pfla_entry_t         link_mem [MAX_PAGES];
    logic                mem_we;
    logic [PAGE_W-1:0]   mem_waddr;
    pfla_entry_t         mem_wdata;

    logic                accept;
    logic [PAGE_W-1:0]   rd_addr;
    logic                mark;
    logic [COUNT_W-1:0]  cfg_clamped;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Allocation reads the current head; a free reads the page it names.
    assign rd_addr = (req.func == FUNC_ALLOC) ? head_reg : req.page_id;

    // Pages 2 and up below the count were all written when the pool grew,
    // so only page 1 can hold a mark that was never written since reset.
    assign mark = rd_data_reg.mark &&
                  ((addr_reg != PAGE_W'(1)) || page1_wr_reg);

    always_comb
    begin
        if (cfg_data < LIMIT_MIN)
            cfg_clamped = LIMIT_MIN;
        else if (cfg_data > LIMIT_MAX)
            cfg_clamped = LIMIT_MAX;
        else
            cfg_clamped = cfg_data;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        page1_wr_next = page1_wr_reg;
        rsp_next      = rsp_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = '{mark: 1'b0, link: rd_data_reg.link};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next           = S_IDLE;
                rsp_next.result_page = '0;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (addr_reg != '0)
                    begin
                        // Pop the list head.
                        if (!mark)
                        begin
                            rsp_next.status = ST_CORRUPT;
                        end
                        else
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = addr_reg;
                            mem_wdata            = '{mark: 1'b0, link: rd_data_reg.link};
                            head_next            = rd_data_reg.link;
                            rsp_next.result_page = addr_reg;
                            rsp_next.status      = ST_OK;
                        end
                    end
                    else if (count_reg >= limit_reg)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        // Grow the pool by one page with its mark cleared.
                        mem_we               = 1'b1;
                        mem_waddr            = count_reg[PAGE_W-1:0];
                        mem_wdata            = '{mark: 1'b0, link: '0};
                        count_next           = count_reg + COUNT_W'(1);
                        rsp_next.result_page = count_reg[PAGE_W-1:0];
                        rsp_next.status      = ST_OK;
                    end
                end
                else
                begin
                    if ((addr_reg == '0) || ({1'b0, addr_reg} >= count_reg))
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else if (mark)
                    begin
                        rsp_next.status = ST_DBL_FREE;
                    end
                    else
                    begin
                        // Push the page onto the list head.
                        mem_we               = 1'b1;
                        mem_waddr            = addr_reg;
                        mem_wdata            = '{mark: 1'b1, link: head_reg};
                        head_next            = addr_reg;
                        rsp_next.result_page = addr_reg;
                        rsp_next.status      = ST_OK;
                    end
                end
                if (mem_we && (mem_waddr == PAGE_W'(1)))
                    page1_wr_next = 1'b1;
                rsp_next.pages_in_use_count = count_next;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= COUNT_RESET;
            head_reg     <= '0;
            limit_reg    <= LIMIT_RESET;
            page1_wr_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            page1_wr_reg <= page1_wr_next;
            done_reg     <= (state_reg == S_EXEC);
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_clamped;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            func_reg <= req.func;
            addr_reg <= rd_addr;
        end
    end

    // Link memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_data_reg <= link_mem[rd_addr];
    end

endmodule

>>> verif/tb.sv
// Self-checking testbench for the page free-list allocator.
`timescale 1ns / 1ps

module tb;
    import pfla_pkg::*;

    // A run that has not finished after this many cycles has hung.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Only the first few mismatches are printed in full.
    localparam int unsigned REPORT_MAX  = 10;

    // Scoreboard with a predictor of the page pool.
    //
    // The class keeps its own copy of the page count, the list head, the
    // next-page links, the free marks and the page limit. Each accepted
    // request item is run through that copy at once, and the result item it
    // must produce is queued. Every result item from the block is then
    // compared against the oldest queued result item.
    class page_pool_scoreboard;
        logic [COUNT_W-1:0] limit_reg;
        logic [COUNT_W-1:0] pool_pages;
        logic [PAGE_W-1:0]  head;
        logic [PAGE_W-1:0]  next_page [MAX_PAGES];
        bit                 is_free   [MAX_PAGES];
        pfla_rsp_t          pending_results [$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        status_hits [8];

        function new();
            limit_reg  = LIMIT_RESET;
            pool_pages = COUNT_RESET;
            head       = '0;
            mismatches = 0;
            checked    = 0;
            foreach (is_free[i])
            begin
                is_free[i]   = 1'b0;
                next_page[i] = '0;
            end
            foreach (status_hits[i])
            begin
                status_hits[i] = 0;
            end
        endfunction

        // Applies one accepted request item to the pool copy and queues the
        // result item that the block must return for it.
        function void note_request(pfla_req_t r);
            pfla_rsp_t          e;
            logic [COUNT_W-1:0] lim;
            logic [PAGE_W-1:0]  id;
            e = '0;
            if (r.func == FUNC_ALLOC)
            begin
                if (head != '0)
                begin
                    id = head;
                    if (!is_free[id])
                    begin
                        e.status = ST_CORRUPT;
                    end
                    else
                    begin
                        head          = next_page[id];
                        is_free[id]   = 1'b0;
                        e.result_page = id;
                        e.status      = ST_OK;
                    end
                end
                else
                begin
                    // The limit register is clamped into the legal range on use.
                    lim = limit_reg;
                    if (lim < LIMIT_MIN)
                    begin
                        lim = LIMIT_MIN;
                    end
                    if (lim > LIMIT_MAX)
                    begin
                        lim = LIMIT_MAX;
                    end
                    if (pool_pages >= lim)
                    begin
                        e.status = ST_FULL;
                    end
                    else
                    begin
                        id            = pool_pages[PAGE_W-1:0];
                        is_free[id]   = 1'b0;
                        pool_pages    = pool_pages + 1'b1;
                        e.result_page = id;
                        e.status      = ST_OK;
                    end
                end
            end
            else if (r.page_id == '0 || {1'b0, r.page_id} >= pool_pages)
            begin
                e.status = ST_RANGE;
            end
            else if (is_free[r.page_id])
            begin
                e.status = ST_DBL_FREE;
            end
            else
            begin
                next_page[r.page_id] = head;
                head                 = r.page_id;
                is_free[r.page_id]   = 1'b1;
                e.result_page        = r.page_id;
                e.status             = ST_OK;
            end
            e.pages_in_use_count = pool_pages;
            pending_results.push_back(e);
        endfunction

        // Compares one result item from the block with the oldest expectation.
        function void check_result(pfla_rsp_t got);
            pfla_rsp_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("result with nothing expected: page %0d status %0d count %0d",
                             got.result_page, got.status, got.pages_in_use_count);
                end
                return;
            end
            e = pending_results.pop_front();
            checked++;
            status_hits[e.status]++;
            if (got.result_page !== e.result_page || got.status !== e.status ||
                got.pages_in_use_count !== e.pages_in_use_count)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch on result %0d (page/status/count):", checked);
                    $display("  expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             e.result_page, e.status, e.pages_in_use_count,
                             got.result_page, got.status, got.pages_in_use_count);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Total failures, counting every expectation that never got its result.
        function int unsigned failures();
            if (pending_results.size() != 0)
            begin
                $display("%0d expected results never arrived", pending_results.size());
            end
            return mismatches + pending_results.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    pfla_req_t           req;
    logic                done;
    pfla_rsp_t           rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;

    page_pool_scoreboard sb;
    int unsigned         cycle_count = 0;
    int unsigned         items_sent;
    int unsigned         limit_writes;

    page_free_list_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result monitor. The receiver cannot stall the block, so every cycle
    // with done high carries one result item that is checked right here.
    // Values are read at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(rsp);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle time for the sender after an item. Every fourth stretch of 40
    // items runs back to back; elsewhere most gaps are short and a few long,
    // so that start rises in every phase of the block's work.
    function automatic int unsigned pick_gap(int unsigned idx);
        int unsigned r;
        if ((idx / 40) % 4 == 1)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(20, 40);
    endfunction

    // Page to free. Most picks are pages that exist, which gives good frees;
    // the rest aim at the error checks: page 0, the id equal to the count,
    // any id at all, and the page at the list head (a guaranteed double free).
    function automatic logic [PAGE_W-1:0] pick_free_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return PAGE_W'($urandom_range(0, MAX_PAGES - 1));
        end
        if (r < 14)
        begin
            return (sb.pool_pages < LIMIT_MAX) ? sb.pool_pages[PAGE_W-1:0] : '0;
        end
        if (r < 17)
        begin
            return '0;
        end
        if (r < 27 && sb.head != '0)
        begin
            return sb.head;
        end
        return PAGE_W'($urandom_range(1, sb.pool_pages - 1));
    endfunction

    function automatic pfla_req_t make_request(int unsigned alloc_pct);
        pfla_req_t r;
        // The page id of an allocate item is ignored, so it is left random.
        r.page_id = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
        if ($urandom_range(1, 100) <= alloc_pct)
        begin
            r.func = FUNC_ALLOC;
        end
        else
        begin
            r.func    = FUNC_FREE;
            r.page_id = pick_free_id();
        end
        return r;
    endfunction

    // Offers one request item and waits for the edge that takes it. The
    // predictor is updated at that edge, so the next pick sees fresh state.
    // start stays high when no gap follows, so the next item can be taken
    // at the next free edge.
    task automatic drive_request(pfla_req_t r);
        int unsigned gap;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
        items_sent++;
        gap = pick_gap(items_sent);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(logic f, logic [PAGE_W-1:0] id);
        pfla_req_t r;
        r.func    = f;
        r.page_id = id;
        drive_request(r);
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Writes the page limit once the block is idle.
    task automatic write_limit(logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.limit_reg = value;
        limit_writes++;
    endtask

    task automatic run_random(int unsigned n, int unsigned alloc_pct);
        repeat (n)
        begin
            drive_request(make_request(alloc_pct));
        end
    endtask

    initial
    begin
        sb           = new();
        items_sent   = 0;
        limit_writes = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset limit. Page 1 exists from reset, so it
        // can be freed at once; page 0 and the id equal to the count are out
        // of range, and a second free of the same page is a double free.
        send(FUNC_FREE, '0);
        send(FUNC_FREE, 10'd1);
        send(FUNC_FREE, 10'd1);
        send(FUNC_FREE, 10'd2);
        // The first allocate pops page 1 (its page id field is ignored), the
        // next two grow the pool once the list is empty.
        send(FUNC_ALLOC, 10'd1023);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, 10'd512);
        send(FUNC_FREE, 10'd1023);
        // Build a list of three pages and pop it back in last-in order.
        send(FUNC_FREE, 10'd3);
        send(FUNC_FREE, 10'd2);
        send(FUNC_FREE, 10'd1);
        send(FUNC_FREE, 10'd2);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, '0);

        // A limit of zero acts as two, far below the current count, so growth
        // reports full while the list still hands out freed pages.
        write_limit('0);
        send(FUNC_ALLOC, '0);
        send(FUNC_FREE, 10'd4);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, '0);
        // Limit equal to the count: full. One above: one growth, then full.
        write_limit(11'd5);
        send(FUNC_ALLOC, '0);
        write_limit(11'd6);
        send(FUNC_ALLOC, '0);
        send(FUNC_ALLOC, '0);
        // All ones acts as the largest pool.
        write_limit(11'd2047);
        send(FUNC_FREE, 10'd1023);
        send(FUNC_FREE, 10'd5);

        // Random part: a small pool that fills quickly, the smallest limit,
        // a mid-size pool, and finally an allocate-heavy run that grows the
        // pool to its full size of 1024 pages (limit just past the maximum,
        // which is clamped). The last phase frees and reuses pages of the full pool.
        write_limit(11'd16);
        run_random(300, 50);
        write_limit(11'd2);
        run_random(60, 50);
        write_limit(11'd300);
        run_random(400, 65);
        write_limit(11'd1025);
        run_random(1050, 92);
        write_limit(11'd1024);
        run_random(30, 50);

        wait_idle();
        repeat (4) @(posedge clk);

        $display("%0d request items sent, %0d results checked over %0d limit settings",
                 items_sent, sb.checked, limit_writes);
        $display("ok %0d, full %0d, out of range %0d, double free %0d; final page count %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_RANGE],
                 sb.status_hits[ST_DBL_FREE], sb.pool_pages);
        if (sb.failures() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pfla_pkg.sv
hw/rtl/page_free_list_allocator_top.sv
verif/tb.sv
